### rtl/core/vst_pkg.sv
// ----------------------------------------------------------------------------
// vst_pkg: shared types and constants of the vertical strip tiler
// Field widths, payload structs, register indexes and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package vst_pkg;

  localparam int unsigned DEF_MAX_SEGMENTS = 64;
  localparam int unsigned DEF_COORD_BITS   = 12;

  localparam int unsigned XW   = 12;          // box_x, box_y, seg_x
  localparam int unsigned SW   = 13;          // sizes and rows
  localparam int unsigned CWW  = 11;          // strip width
  localparam int unsigned OVW  = 12;          // overlap
  localparam int unsigned IDXW = 6;           // seg_index
  localparam int unsigned Y2W  = 14;          // box bottom row

  localparam int unsigned MAW  = 14;          // multiplier operand a
  localparam int unsigned MBW  = 13;          // multiplier operand b
  localparam int unsigned PW   = MAW + MBW;   // product

  localparam int unsigned NUMW = 35;          // signed numerators, 1/strip_width units
  localparam int unsigned MAGW = NUMW - 1;    // numerator magnitude
  localparam int unsigned QW   = NUMW + 1;    // signed rounded quotient
  localparam int unsigned DENW = 13;          // divisor

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIP_WIDTH        = 2'd0,
    CFG_STRIP_HEIGHT       = 2'd1,
    CFG_MAX_CONTENT_HEIGHT = 2'd2,
    CFG_OVERLAP_PIXELS     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [XW-1:0] box_x;
    logic [XW-1:0] box_y;
    logic [SW-1:0] box_width;
    logic [SW-1:0] box_height;
  } box_t;

  typedef struct packed {
    logic [XW-1:0]   seg_x;
    logic [SW-1:0]   seg_top;
    logic [SW-1:0]   seg_width;
    logic [SW-1:0]   seg_height;
    logic [CWW-1:0]  content_width;
    logic [SW-1:0]   content_height;
    logic [IDXW-1:0] seg_index;
    logic            last;
    logic            truncated;
  } seg_t;

  typedef enum logic [2:0] {
    PREP_SPLIT_A = 3'd0,
    PREP_SPLIT_B = 3'd1,
    PREP_SEGNUM  = 3'd2,
    PREP_STRIDE  = 3'd3,
    PREP_BASE    = 3'd4,
    PREP_Y2N     = 3'd5
  } prep_e;

  typedef enum logic [1:0] {
    DIV_TOP = 2'd0,
    DIV_BOT = 2'd1,
    DIV_CH  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic      load;
    logic      prep;
    prep_e     prep_sel;
    logic      scan;
    logic      anchor;
    logic      seg_init;
    logic      div_go;
    logic      div_take;
    div_sel_e  div_sel;
    logic      mul_h;
    logic      push;
    logic      flush;
    logic      seg_next;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic split;
    logic scan_more;
    logic seg_more;
    logic seg_valid;
    logic div_done;
    logic out_free;
    logic pend_v;
  } sts_t;

endpackage

### rtl/core/vst_div.sv
// ----------------------------------------------------------------------------
// vst_div: iterative divider with half-to-even rounding
// Restoring division, one quotient bit per cycle, then a rounding step that turns
// the truncated result into a floor and rounds half to even.
// ----------------------------------------------------------------------------
module vst_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [vst_pkg::NUMW-1:0]  num_i,
  input  logic        [vst_pkg::DENW-1:0]  den_i,
  output logic                             done_o,
  output logic signed [vst_pkg::QW-1:0]    q_o
);

  localparam int unsigned MAGW = vst_pkg::MAGW;
  localparam int unsigned DENW = vst_pkg::DENW;
  localparam int unsigned QW   = vst_pkg::QW;
  localparam int unsigned CW   = $clog2(MAGW + 1);

  logic                  busy_q, rnd_q, done_q;
  logic [CW-1:0]         cnt_q;
  logic                  neg_q;
  logic [DENW-1:0]       den_q;
  logic [MAGW-1:0]       quo_q;
  logic [DENW-1:0]       rem_q;
  logic signed [QW-1:0]  q_q;

  logic signed [vst_pkg::NUMW-1:0] mag;
  logic [DENW:0]         trial, diff;
  logic                  ge;
  logic signed [QW-1:0]  q0, qf, qr;
  logic [DENW-1:0]       rf;
  logic [DENW:0]         two_r;

  assign mag   = num_i[vst_pkg::NUMW-1] ? -num_i : num_i;
  assign trial = {rem_q, quo_q[MAGW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // floor for negative numerators, then round half to even
  always_comb begin
    q0 = $signed(QW'(quo_q));
    qf = q0;
    rf = rem_q;
    if (neg_q) begin
      if (rem_q != '0) begin
        qf = -q0 - QW'(1);
        rf = den_q - rem_q;
      end else begin
        qf = -q0;
      end
    end
    two_r = {rf, 1'b0};
    if (two_r > {1'b0, den_q} || (two_r == {1'b0, den_q} && qf[0])) begin
      qr = qf + QW'(1);
    end else begin
      qr = qf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= 1'b0;
        cnt_q  <= CW'(MAGW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          rnd_q  <= 1'b1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[vst_pkg::NUMW-1];
      den_q <= den_i;
      quo_q <= mag[MAGW-1:0];
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
      quo_q <= {quo_q[MAGW-2:0], ge};
    end else if (rnd_q) begin
      q_q <= qr;
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

### rtl/core/vst_dp.sv
// ----------------------------------------------------------------------------
// vst_dp: datapath of the vertical strip tiler
// Configuration registers, box registers, shared multiplier, window scan,
// per-segment divisions, and the pending and output segment registers.
// ----------------------------------------------------------------------------
module vst_dp #(
  parameter int unsigned MAX_SEGMENTS = vst_pkg::DEF_MAX_SEGMENTS,
  parameter int unsigned COORD_BITS   = vst_pkg::DEF_COORD_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [vst_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vst_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  vst_pkg::box_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vst_pkg::seg_t                     out_data_o,
  input  vst_pkg::cmd_t                     cmd_i,
  output vst_pkg::sts_t                     sts_o
);

  localparam int unsigned XW   = vst_pkg::XW;
  localparam int unsigned SW   = vst_pkg::SW;
  localparam int unsigned CWW  = vst_pkg::CWW;
  localparam int unsigned OVW  = vst_pkg::OVW;
  localparam int unsigned Y2W  = vst_pkg::Y2W;
  localparam int unsigned MAW  = vst_pkg::MAW;
  localparam int unsigned MBW  = vst_pkg::MBW;
  localparam int unsigned PW   = vst_pkg::PW;
  localparam int unsigned NUMW = vst_pkg::NUMW;
  localparam int unsigned QW   = vst_pkg::QW;
  localparam int unsigned DENW = vst_pkg::DENW;
  localparam int unsigned CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [XW-1:0] CMASK =
    (COORD_BITS >= XW) ? {XW{1'b1}} : XW'((1 << COORD_BITS) - 1);

  // configuration
  logic [CWW-1:0] sw_q;
  logic [SW-1:0]  sh_q, mch_q;
  logic [OVW-1:0] ov_q;

  // box
  logic [XW-1:0]  bx_q, by_q;
  logic [SW-1:0]  bw_q, bh_q;
  logic [Y2W-1:0] y2;

  // setup and scan
  logic [PW-1:0]          pa_q;
  logic                   split_q;
  logic signed [NUMW-1:0] segnum_q, stride_q, y2n_q, base_q, cur_q, s_q, lastn_q;
  logic [DENW-1:0]        denom_q;
  logic [SW-1:0]          limit_q;
  logic [CNTW-1:0]        count_q, k_q;
  logic                   anch_q, trunc_q;

  // per segment
  logic signed [QW-1:0]   top_q, bot_q, h;
  logic [PW-1:0]          hw_q;
  logic [SW-1:0]          ch_q;

  // segment registers
  vst_pkg::seg_t          pend_q, out_q, seg_new, pend_out;
  logic                   pend_v_q, out_v_q;
  logic                   hand_off;

  logic [MAW-1:0]         mul_a;
  logic [MBW-1:0]         mul_b;
  logic [PW-1:0]          prod;
  logic signed [NUMW-1:0] prod_s;
  logic                   m_gt_o;
  logic [SW-1:0]          m_minus_o;
  logic                   cont, at_max, need;
  logic signed [NUMW-1:0] lastn, prev;
  logic [CNTW-1:0]        total;

  logic                   div_done;
  logic signed [NUMW-1:0] div_num;
  logic [DENW-1:0]        div_den;
  logic signed [QW-1:0]   div_q;

  assign y2        = Y2W'(by_q) + Y2W'(bh_q);
  assign m_gt_o    = mch_q > SW'(ov_q);
  assign m_minus_o = mch_q - SW'(ov_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_h) begin
      mul_a = h[MAW-1:0];
      mul_b = MBW'(sw_q);
    end else begin
      case (cmd_i.prep_sel)
        vst_pkg::PREP_SPLIT_A: begin
          mul_a = MAW'(bh_q);
          mul_b = MBW'(sw_q);
        end
        vst_pkg::PREP_SPLIT_B: begin
          mul_a = MAW'(sh_q);
          mul_b = bw_q;
        end
        vst_pkg::PREP_SEGNUM: begin
          mul_a = MAW'(mch_q);
          mul_b = bw_q;
        end
        vst_pkg::PREP_STRIDE: begin
          mul_a = MAW'(m_minus_o);
          mul_b = bw_q;
        end
        vst_pkg::PREP_BASE: begin
          mul_a = MAW'(by_q);
          mul_b = MBW'(sw_q);
        end
        vst_pkg::PREP_Y2N: begin
          mul_a = y2;
          mul_b = MBW'(sw_q);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign prod   = PW'(mul_a) * PW'(mul_b);
  assign prod_s = $signed(NUMW'(prod));

  // window scan and bottom-anchored window
  assign cont   = (cur_q + segnum_q) < y2n_q;
  assign at_max = count_q == CNTW'(MAX_SEGMENTS);
  assign lastn  = y2n_q - segnum_q;
  assign prev   = cur_q - stride_q + $signed(NUMW'(sw_q));
  assign need   = (count_q == '0) || (lastn > prev);
  assign total  = count_q + CNTW'(anch_q);
  assign h      = bot_q - top_q;

  always_comb begin
    div_num = s_q;
    div_den = denom_q;
    case (cmd_i.div_sel)
      vst_pkg::DIV_TOP: begin
        div_num = s_q;
        div_den = denom_q;
      end
      vst_pkg::DIV_BOT: begin
        div_num = s_q + segnum_q;
        div_den = denom_q;
      end
      vst_pkg::DIV_CH: begin
        div_num = $signed(NUMW'(hw_q));
        div_den = bw_q;
      end
      default: begin
        div_num = s_q;
        div_den = denom_q;
      end
    endcase
  end

  vst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_comb begin
    seg_new.seg_x          = bx_q;
    seg_new.seg_top        = top_q[SW-1:0];
    seg_new.seg_width      = bw_q;
    seg_new.seg_height     = h[SW-1:0];
    seg_new.content_width  = sw_q;
    seg_new.content_height = ch_q;
    seg_new.seg_index      = vst_pkg::IDXW'(k_q);
    seg_new.last           = 1'b0;
    seg_new.truncated      = trunc_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= CWW'(64);
      sh_q  <= SW'(512);
      mch_q <= SW'(480);
      ov_q  <= OVW'(32);
    end else if (cfg_valid_i) begin
      case (vst_pkg::cfg_idx_e'(cfg_index_i))
        vst_pkg::CFG_STRIP_WIDTH:        sw_q  <= cfg_data_i[CWW-1:0];
        vst_pkg::CFG_STRIP_HEIGHT:       sh_q  <= cfg_data_i[SW-1:0];
        vst_pkg::CFG_MAX_CONTENT_HEIGHT: mch_q <= cfg_data_i[SW-1:0];
        vst_pkg::CFG_OVERLAP_PIXELS:     ov_q  <= cfg_data_i[OVW-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bx_q    <= in_data_i.box_x & CMASK;
      by_q    <= in_data_i.box_y & CMASK;
      bw_q    <= in_data_i.box_width;
      bh_q    <= in_data_i.box_height;
      trunc_q <= 1'b0;
    end
    if (cmd_i.prep) begin
      case (cmd_i.prep_sel)
        vst_pkg::PREP_SPLIT_A: pa_q <= prod;
        vst_pkg::PREP_SPLIT_B: split_q <= pa_q > prod;
        vst_pkg::PREP_SEGNUM: begin
          segnum_q <= split_q ? prod_s : $signed(NUMW'(bh_q));
          denom_q  <= split_q ? DENW'(sw_q) : DENW'(1);
          limit_q  <= split_q ? mch_q : sh_q;
        end
        vst_pkg::PREP_STRIDE: stride_q <= (split_q && m_gt_o) ? prod_s : '0;
        vst_pkg::PREP_BASE: begin
          base_q  <= split_q ? prod_s : $signed(NUMW'(by_q));
          cur_q   <= split_q ? prod_s : $signed(NUMW'(by_q));
          count_q <= '0;
        end
        vst_pkg::PREP_Y2N: y2n_q <= prod_s;
        default: ;
      endcase
    end
    if (cmd_i.scan) begin
      count_q <= count_q + CNTW'(1);
      cur_q   <= cur_q + stride_q;
    end
    if (cmd_i.anchor) begin
      lastn_q <= lastn;
      anch_q  <= split_q && need && !at_max;
      if (!split_q) begin
        count_q <= CNTW'(1);
      end else if (at_max && (cont || need)) begin
        trunc_q <= 1'b1;
      end
    end
    if (cmd_i.seg_init) begin
      k_q <= '0;
      // with no evenly spaced window the first one is the bottom-anchored one
      s_q <= (split_q && count_q == '0) ? lastn : base_q;
    end
    if (cmd_i.seg_next) begin
      k_q <= k_q + CNTW'(1);
      // the window after the evenly spaced ones is the bottom-anchored one
      if (k_q + CNTW'(1) == count_q) begin
        s_q <= lastn_q;
      end else begin
        s_q <= s_q + stride_q;
      end
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        vst_pkg::DIV_TOP: top_q <= (div_q < 0) ? '0 : div_q;
        vst_pkg::DIV_BOT: bot_q <= (div_q > $signed(QW'(y2))) ? $signed(QW'(y2)) : div_q;
        vst_pkg::DIV_CH:  ch_q  <= (div_q > $signed(QW'(limit_q))) ? limit_q : div_q[SW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.mul_h) begin
      hw_q <= prod;
    end
  end

  // pending and output segment registers
  assign hand_off = (cmd_i.push || cmd_i.flush) && pend_v_q;

  always_comb begin
    pend_out      = pend_q;
    pend_out.last = cmd_i.flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (hand_off) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_q <= seg_new;
    end
    if (hand_off) begin
      out_q <= pend_out;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.empty     = (in_data_i.box_width == '0) || (in_data_i.box_height == '0);
    sts_o.split     = split_q;
    sts_o.scan_more = cont && (count_q < CNTW'(MAX_SEGMENTS));
    sts_o.seg_more  = k_q < total;
    sts_o.seg_valid = h > 0;
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_v_q || !out_stall_i;
    sts_o.pend_v    = pend_v_q;
  end

endmodule

### rtl/core/vst_ctrl.sv
// ----------------------------------------------------------------------------
// vst_ctrl: controller of the vertical strip tiler
// Sequences setup products, the window scan, the per-segment divisions and
// the hand-off of finished segments to the output register.
// ----------------------------------------------------------------------------
module vst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vst_pkg::sts_t sts_i,
  output vst_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_PREP     = 11'b000_0000_0010,
    S_SCAN     = 11'b000_0000_0100,
    S_ANCHOR   = 11'b000_0000_1000,
    S_SEG_CHK  = 11'b000_0001_0000,
    S_DIV_GO   = 11'b000_0010_0000,
    S_DIV_WAIT = 11'b000_0100_0000,
    S_MUL_H    = 11'b000_1000_0000,
    S_EMIT     = 11'b001_0000_0000,
    S_SEG_NEXT = 11'b010_0000_0000,
    S_FLUSH    = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  vst_pkg::prep_e    prep_q, prep_d;
  vst_pkg::div_sel_e div_sel_q, div_sel_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d   = state_q;
    prep_d    = prep_q;
    div_sel_d = div_sel_q;
    cmd_o          = '0;
    cmd_o.prep_sel = prep_q;
    cmd_o.div_sel  = div_sel_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          prep_d     = vst_pkg::PREP_SPLIT_A;
          if (!sts_i.empty) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        case (prep_q)
          vst_pkg::PREP_SPLIT_A: prep_d = vst_pkg::PREP_SPLIT_B;
          vst_pkg::PREP_SPLIT_B: prep_d = vst_pkg::PREP_SEGNUM;
          vst_pkg::PREP_SEGNUM:  prep_d = vst_pkg::PREP_STRIDE;
          vst_pkg::PREP_STRIDE:  prep_d = vst_pkg::PREP_BASE;
          vst_pkg::PREP_BASE:    prep_d = vst_pkg::PREP_Y2N;
          default: state_d = sts_i.split ? S_SCAN : S_ANCHOR;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.scan = 1'b1;
        end else begin
          state_d = S_ANCHOR;
        end
      end
      S_ANCHOR: begin
        cmd_o.anchor   = 1'b1;
        cmd_o.seg_init = 1'b1;
        state_d        = S_SEG_CHK;
      end
      S_SEG_CHK: begin
        div_sel_d = vst_pkg::DIV_TOP;
        state_d   = sts_i.seg_more ? S_DIV_GO : S_FLUSH;
      end
      S_DIV_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          case (div_sel_q)
            vst_pkg::DIV_TOP: begin
              div_sel_d = vst_pkg::DIV_BOT;
              state_d   = S_DIV_GO;
            end
            vst_pkg::DIV_BOT: state_d = S_MUL_H;
            default:          state_d = S_EMIT;
          endcase
        end
      end
      S_MUL_H: begin
        // empty windows are skipped but keep their index
        if (sts_i.seg_valid) begin
          cmd_o.mul_h = 1'b1;
          div_sel_d   = vst_pkg::DIV_CH;
          state_d     = S_DIV_GO;
        end else begin
          state_d = S_SEG_NEXT;
        end
      end
      S_EMIT: begin
        if (!sts_i.pend_v || sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_SEG_NEXT;
        end
      end
      S_SEG_NEXT: begin
        cmd_o.seg_next = 1'b1;
        state_d        = S_SEG_CHK;
      end
      S_FLUSH: begin
        if (!sts_i.pend_v || sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      prep_q    <= vst_pkg::PREP_SPLIT_A;
      div_sel_q <= vst_pkg::DIV_TOP;
    end else begin
      state_q   <= state_d;
      prep_q    <= prep_d;
      div_sel_q <= div_sel_d;
    end
  end

endmodule

### rtl/core/vertical_strip_tiler.sv
// ----------------------------------------------------------------------------
// vertical_strip_tiler: cuts a text box into overlapping strips
// One box is taken at a time and yields up to MAX_SEGMENTS segments, the
// final one flagged last; an empty box yields none. A box runs its setup
// products on the shared multiplier, a scan over the windows, and for each
// window up to three divisions in the bit-serial divider (one quotient bit
// per cycle over 34 bits, plus start, rounding and hand-back) and then
// control and output hand-off, which waits while the output is stalled.
// A new box is taken once the previous one has handed its last segment to
// the output register.
// ----------------------------------------------------------------------------
module vertical_strip_tiler #(
  parameter int unsigned MAX_SEGMENTS = vst_pkg::DEF_MAX_SEGMENTS,
  parameter int unsigned COORD_BITS   = vst_pkg::DEF_COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  vst_pkg::box_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output vst_pkg::seg_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vst_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  vst_pkg::cmd_t cmd;
  vst_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  vst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vst_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

### sim/vertical_strip_tiler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertical_strip_tiler_tb: self-checking bench for the strip tiler
// Boxes go in under several register settings, from a short directed table
// and then at random; each segment out is checked field by field against
// its table entry or a predictor cutting the box in exact integer arithmetic.
// ----------------------------------------------------------------------------
module vertical_strip_tiler_tb;
  import vst_pkg::*;

  localparam int  MAX_SEG    = 64;
  localparam int  SETTLE     = 8200;     // longest box
  localparam int  LIMIT      = 20000000;
  localparam int  N_PHASES   = 11;
  localparam int  QUIET_TAIL = 30;

  typedef struct {
    box_t  box;
    bit    typed;     // expectation written out below instead of predicted
    int    n_typed;
    seg_t  seg;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  box_t in_data = '0;
  logic out_stall = 1'b1;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STRIP_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  seg_t out_data;

  // predictor copy of the registers
  logic [10:0] strip_w;
  logic [12:0] strip_h;
  logic [12:0] content_max;
  logic [11:0] overlap;

  seg_t segs_due[$];
  row_t rows_sent[$];
  int   fails = 0;
  int   boxes_taken = 0;
  int   boxes_driven = 0;
  int   total_boxes = 0;
  bit   quiet = 1'b0;
  longint cycles = 0;

  vertical_strip_tiler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** vertical_strip_tiler: FAILED **");
      $finish;
    end
  end

  // round half to even, d > 0
  function automatic longint round_even(longint n, longint d);
    longint q, r;
    q = n / d;
    r = n % d;
    if (r < 0) begin
      q = q - 1;
      r = r + d;
    end
    if (2 * r > d || (2 * r == d && (q % 2) != 0)) q = q + 1;
    return q;
  endfunction

  function automatic void cut_box(box_t b);
    longint bx, by, bw, bh, w, sh, m, o, y2;
    longint segnum, denom, lim, stride, y2n, cur, lastn, top, bot, h, ch;
    longint starts[$];
    seg_t   found[$];
    seg_t   s;
    bit     trunc;
    bx = b.box_x; by = b.box_y; bw = b.box_width; bh = b.box_height;
    w = strip_w; sh = strip_h; m = content_max; o = overlap;
    y2 = by + bh;
    trunc = 1'b0;
    if (bw == 0 || bh == 0) return;
    if (bh * w > sh * bw) begin
      stride = (m > o) ? (m - o) * bw : 0;
      y2n = y2 * w;
      cur = by * w;
      segnum = m * bw;
      denom = w;
      lim = m;
      while (starts.size() < MAX_SEG && cur + segnum < y2n) begin
        starts.push_back(cur);
        cur = cur + stride;
      end
      if (starts.size() == MAX_SEG && cur + segnum < y2n) begin
        trunc = 1'b1;
      end else begin
        lastn = y2n - segnum;
        if (starts.size() == 0 || lastn > starts[$] + w) begin
          if (starts.size() == MAX_SEG) trunc = 1'b1;
          else starts.push_back(lastn);
        end
      end
    end else begin
      starts.push_back(by);
      segnum = bh;
      denom = 1;
      lim = sh;
    end
    foreach (starts[k]) begin
      top = round_even(starts[k], denom);
      bot = round_even(starts[k] + segnum, denom);
      if (bot > y2) bot = y2;
      if (top < 0) top = 0;
      h = bot - top;
      if (h > 0) begin
        ch = round_even(h * w, bw);
        if (ch > lim) ch = lim;
        s.seg_x          = bx[11:0];
        s.seg_top        = top[12:0];
        s.seg_width      = bw[12:0];
        s.seg_height     = h[12:0];
        s.content_width  = w[10:0];
        s.content_height = ch[12:0];
        s.seg_index      = k[5:0];
        s.last           = 1'b0;
        s.truncated      = trunc;
        found.push_back(s);
      end
    end
    if (found.size() > 0) found[$].last = 1'b1;
    foreach (found[i]) segs_due.push_back(found[i]);
  endfunction

  // input and register monitor
  always @(posedge clk_i) begin
    row_t r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_e'(cfg_index))
        CFG_STRIP_WIDTH:        strip_w     = cfg_data[10:0];
        CFG_STRIP_HEIGHT:       strip_h     = cfg_data[12:0];
        CFG_MAX_CONTENT_HEIGHT: content_max = cfg_data[12:0];
        CFG_OVERLAP_PIXELS:     overlap     = cfg_data[11:0];
        default: ;
      endcase
    end
    if (in_valid && !in_stall) begin
      r = rows_sent.pop_front();
      boxes_taken++;
      if (r.typed) begin
        if (r.n_typed > 0) segs_due.push_back(r.seg);
      end else begin
        cut_box(r.box);
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // segment checker
  always @(posedge clk_i) begin
    seg_t e;
    if (out_valid && !out_stall) begin
      if (segs_due.size() == 0) begin
        $error("segment with no expectation: %p", out_data);
        fails++;
      end else begin
        e = segs_due.pop_front();
        check_field("seg_x", e.seg_x, out_data.seg_x);
        check_field("seg_top", e.seg_top, out_data.seg_top);
        check_field("seg_width", e.seg_width, out_data.seg_width);
        check_field("seg_height", e.seg_height, out_data.seg_height);
        check_field("content_width", e.content_width, out_data.content_width);
        check_field("content_height", e.content_height, out_data.content_height);
        check_field("seg_index", e.seg_index, out_data.seg_index);
        check_field("last", e.last, out_data.last);
        check_field("truncated", e.truncated, out_data.truncated);
      end
    end
  end

  // receiver: random stall bursts, calm stretches, and one long hold-off
  initial begin
    bit held;
    int calm;
    held = 1'b0;
    calm = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && boxes_taken >= 30) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
      end else if (!quiet && calm == 0 && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(50, 200);
      end
      out_stall <= 1'b0;
      if (calm > 0) calm--;
      @(posedge clk_i);
    end
  end

  task automatic send_box(row_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    rows_sent.push_back(r);
    boxes_driven++;
    if (boxes_driven > total_boxes - QUIET_TAIL) quiet = 1'b1;
    in_valid <= 1'b1;
    in_data  <= r.box;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_regs(int w, int sh, int m, int o);
    write_reg(CFG_STRIP_WIDTH, w);
    write_reg(CFG_STRIP_HEIGHT, sh);
    write_reg(CFG_MAX_CONTENT_HEIGHT, m);
    write_reg(CFG_OVERLAP_PIXELS, o);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (segs_due.size() != 0 || rows_sent.size() != 0) @(posedge clk_i);
    // a box with no segments may still be busy
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic row_t random_row();
    row_t r;
    int pick;
    r.typed = 1'b0;
    r.n_typed = 0;
    r.seg = '0;
    r.box.box_x = $urandom_range(0, 4095);
    r.box.box_y = $urandom_range(0, 4095);
    pick = $urandom_range(0, 99);
    if (pick < 3) r.box.box_width = 0;
    else if (pick < 23) r.box.box_width = $urandom_range(1, 255);
    else r.box.box_width = $urandom_range(256, 4096);
    r.box.box_height = ($urandom_range(0, 49) == 0) ? 0 : $urandom_range(1, 4096);
    return r;
  endfunction

  function automatic row_t plain_row(int x, int y, int w, int h);
    row_t r;
    r.box = '{box_x: x, box_y: y, box_width: w, box_height: h};
    r.typed = 1'b0;
    r.n_typed = 0;
    r.seg = '0;
    return r;
  endfunction

  initial begin
    row_t table_rows[$];
    row_t r;
    int   ph_cfg[N_PHASES][4];
    int   ph_items[N_PHASES];
    int   m;

    // single segment at reset settings
    r = plain_row(0, 0, 64, 64);
    r.typed = 1'b1; r.n_typed = 1;
    r.seg = '{seg_x: 0, seg_top: 0, seg_width: 64, seg_height: 64, content_width: 64,
              content_height: 64, seg_index: 0, last: 1'b1, truncated: 1'b0};
    table_rows.push_back(r);
    // empty boxes give nothing
    r = plain_row(100, 100, 0, 50); r.typed = 1'b1; table_rows.push_back(r);
    r = plain_row(100, 100, 50, 0); r.typed = 1'b1; table_rows.push_back(r);
    // corner of the coordinate range, content rounds down to zero
    r = plain_row(4095, 4095, 4096, 1);
    r.typed = 1'b1; r.n_typed = 1;
    r.seg = '{seg_x: 4095, seg_top: 4095, seg_width: 4096, seg_height: 1, content_width: 64,
              content_height: 0, seg_index: 0, last: 1'b1, truncated: 1'b0};
    table_rows.push_back(r);
    table_rows.push_back(plain_row(0, 0, 4096, 4096));
    table_rows.push_back(plain_row(10, 20, 64, 2000));
    table_rows.push_back(plain_row(4095, 4095, 300, 4096));
    table_rows.push_back(plain_row(0, 0, 1, 4096));
    table_rows.push_back(plain_row(7, 513, 64, 513));
    table_rows.push_back(plain_row(2730, 1365, 100, 1500));

    // strip width, strip height, content height, overlap, items
    ph_cfg[0] = '{1024, 4096, 4096, 4095}; ph_items[0] = 12;
    ph_cfg[1] = '{1, 1, 1, 0};             ph_items[1] = 12;
    ph_cfg[2] = '{13'h1800, 512, 480, 32}; ph_items[2] = 10;   // width masks to zero
    ph_cfg[3] = '{64, 64, 4096, 0};        ph_items[3] = 10;   // windows above row zero
    ph_cfg[4] = '{32, 512, 0, 0};          ph_items[4] = 6;    // every split window empty
    ph_cfg[5] = '{64, 512, 100, 200};      ph_items[5] = 8;    // overlap past content
    ph_cfg[6] = '{2047, 8191, 8191, 4095}; ph_items[6] = 8;
    for (int p = 7; p < N_PHASES; p++) begin
      m = $urandom_range(200, 4096);
      ph_cfg[p] = '{$urandom_range(1, 1024), $urandom_range(64, 4096), m,
                    $urandom_range(0, m / 2)};
      ph_items[p] = 40;
    end
    total_boxes = table_rows.size();
    foreach (ph_items[p]) total_boxes += ph_items[p];

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    strip_w = 64; strip_h = 512; content_max = 480; overlap = 32;

    foreach (table_rows[i]) send_box(table_rows[i]);
    drain();
    for (int p = 0; p < N_PHASES; p++) begin
      set_regs(ph_cfg[p][0], ph_cfg[p][1], ph_cfg[p][2], ph_cfg[p][3]);
      for (int i = 0; i < ph_items[p]; i++) send_box(random_row());
      drain();
    end

    if (fails == 0) begin
      $display("** vertical_strip_tiler: PASSED **");
    end else begin
      $display("** vertical_strip_tiler: FAILED **");
    end
    $finish;
  end

endmodule
